>>> rtl/core/tbmp_pkg.sv
// Types, codes and constants shared by the token bucket message policer.
// No dependencies; every other file of the core refers to it by scoped names.
package tbmp_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_BURST_TOKENS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFILL_PER_SECOND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VIOLATIONS    = 2'd2;

  localparam logic [9:0]  BURST_TOKENS_RESET      = 10'd20;
  localparam logic [16:0] REFILL_PER_SECOND_RESET = 17'd10;
  localparam logic [7:0]  MAX_VIOLATIONS_RESET    = 8'd10;

  localparam logic [19:0] MILLI_PER_TOKEN = 20'd1000;
  localparam logic [19:0] EXTRA_STATE     = 20'd2000;
  localparam logic [19:0] EXTRA_QUERY     = 20'd4000;
  localparam logic [7:0]  VIOLATIONS_MAX  = 8'd255;

  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_STATE   = 2'd1,
    KIND_FIGHT   = 2'd2,
    KIND_CATALOG = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT  = 3'd0,
    VERDICT_IGNORED = 3'd1,
    VERDICT_RATE    = 3'd2,
    VERDICT_PARSE   = 3'd3,
    VERDICT_REFUSED = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [9:0]  burst_tokens;
    logic [16:0] refill_per_second;
    logic [7:0]  max_violations;
  } cfg_t;

  typedef struct packed {
    logic [19:0] level_milli;
    logic [63:0] last_time;
    logic        bucket_started;
    logic [7:0]  violation_count;
    logic        is_closing;
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [63:0] now_ms;
    logic        parse_ok;
    logic [1:0]  command_kind;
    logic        later_refused;
  } word_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        close_now;
    logic [19:0] tokens_left;
  } result_t;

endpackage

>>> rtl/core/tbmp_if.sv
// Valid/ready channel interfaces for the policer's input and result words.
// Depends on tbmp_pkg for the verdict type.
interface tbmp_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] now_ms;
  logic        parse_ok;
  logic [1:0]  command_kind;
  logic        later_refused;

  modport source (output valid, cmd, now_ms, parse_ok, command_kind, later_refused,
                  input ready);
  modport sink   (input valid, cmd, now_ms, parse_ok, command_kind, later_refused,
                  output ready);
endinterface

interface tbmp_result_if;
  logic               valid;
  logic               ready;
  tbmp_pkg::verdict_t verdict;
  logic               close_now;
  logic [19:0]        tokens_left;

  modport source (output valid, verdict, close_now, tokens_left, input ready);
  modport sink   (input valid, verdict, close_now, tokens_left, output ready);
endinterface

>>> rtl/core/token_bucket_message_policer_core.sv
// Token bucket message policer for one connection: top level.
// Depends on tbmp_pkg, tbmp_if (channel interfaces) and tbmp_update.
//
// Input words arrive on the item channel (valid/ready): cmd 0 is a message
// with its arrival time, parse status, command kind and upstream refusal;
// cmd 1 is a new connection and returns the bucket, the violation count and
// the closing flag to zero. Every word gives exactly one result word on the
// result channel: verdict, close_now and the bucket level in milli-tokens.
// Configuration (burst_tokens, refill_per_second, max_violations) is written
// through cfg_write/cfg_index/cfg_data; the user must do so only while no
// word is in flight, as the block itself does not enforce it. The word is
// held in one input register and its result in one result register, with the
// refill multiply and charge compares in a single pass between them.
// Throughput is one word per cycle while the receiver takes results; the
// bucket state register closes a loop through that pass.
// Reset (rst, synchronous) restores the register defaults and clears state.
// When the receiver stalls, the result is held and one more word is taken
// into the input register; ready then drops until the result moves on.
module token_bucket_message_policer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [tbmp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tbmp_pkg::CFG_DATA_W-1:0]       cfg_data,
  tbmp_item_if.sink                             item,
  tbmp_result_if.source                         result
);

  tbmp_pkg::cfg_t    cfg;
  tbmp_pkg::state_t  state;
  tbmp_pkg::state_t  state_next;
  tbmp_pkg::word_t   word;
  tbmp_pkg::result_t res_next;
  tbmp_pkg::result_t res;
  logic              word_valid;
  logic              result_valid;
  logic              advance;

  assign advance    = word_valid && (!result_valid || result.ready);
  assign item.ready = !word_valid || advance;

  tbmp_update u_update (
    .cfg        (cfg),
    .state      (state),
    .word       (word),
    .state_next (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_tokens      <= tbmp_pkg::BURST_TOKENS_RESET;
      cfg.refill_per_second <= tbmp_pkg::REFILL_PER_SECOND_RESET;
      cfg.max_violations    <= tbmp_pkg::MAX_VIOLATIONS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tbmp_pkg::CFG_BURST_TOKENS:      cfg.burst_tokens      <= cfg_data[9:0];
        tbmp_pkg::CFG_REFILL_PER_SECOND: cfg.refill_per_second <= cfg_data;
        tbmp_pkg::CFG_MAX_VIOLATIONS:    cfg.max_violations    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= '0;
    end else begin
      if (item.valid && item.ready) begin
        word_valid <= 1'b1;
      end else if (advance) begin
        word_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state        <= state_next;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      word.cmd           <= item.cmd;
      word.now_ms        <= item.now_ms;
      word.parse_ok      <= item.parse_ok;
      word.command_kind  <= item.command_kind;
      word.later_refused <= item.later_refused;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid       = result_valid;
  assign result.verdict     = res.verdict;
  assign result.close_now   = res.close_now;
  assign result.tokens_left = res.tokens_left;

endmodule

>>> rtl/core/tbmp_update.sv
// Single-pass bucket update: refill, charge and violation logic for one word.
// Depends on tbmp_pkg for the state, config, word and result types.
module tbmp_update (
  input  tbmp_pkg::cfg_t    cfg,
  input  tbmp_pkg::state_t  state,
  input  tbmp_pkg::word_t   word,
  output tbmp_pkg::state_t  state_next,
  output tbmp_pkg::result_t res
);

  logic [19:0] cap;
  logic [19:0] level_start;
  logic [63:0] last_start;
  logic        later;
  logic [63:0] diff;
  logic        diff_big;
  logic [36:0] prod;
  logic [36:0] add;
  logic [37:0] sum;
  logic [19:0] level_fill;
  logic [63:0] last_fill;
  logic [19:0] extra;
  logic [19:0] level_one;
  logic [19:0] level_out;
  logic [7:0]  count_inc;
  tbmp_pkg::verdict_t verdict;

  assign cap         = 20'({10'd0, cfg.burst_tokens} * tbmp_pkg::MILLI_PER_TOKEN);
  assign level_start = state.bucket_started ? state.level_milli : cap;
  assign last_start  = state.bucket_started ? state.last_time : word.now_ms;
  assign later       = word.now_ms > last_start;
  assign diff        = word.now_ms - last_start;
  assign diff_big    = diff > {44'd0, cap};
  assign prod        = 37'(diff[19:0]) * 37'(cfg.refill_per_second);
  assign add         = diff_big ? ((cfg.refill_per_second == '0) ? 37'd0 : 37'(cap)) : prod;
  assign sum         = 38'(level_start) + 38'(add);
  assign level_fill  = later ? ((sum < 38'(cap)) ? sum[19:0] : cap) : level_start;
  assign last_fill   = later ? word.now_ms : last_start;
  assign level_one   = level_fill - tbmp_pkg::MILLI_PER_TOKEN;
  assign count_inc   = (state.violation_count == tbmp_pkg::VIOLATIONS_MAX) ?
                       state.violation_count : state.violation_count + 8'd1;

  always_comb begin
    case (tbmp_pkg::kind_t'(word.command_kind))
      tbmp_pkg::KIND_OTHER:   extra = '0;
      tbmp_pkg::KIND_STATE:   extra = tbmp_pkg::EXTRA_STATE;
      tbmp_pkg::KIND_FIGHT:   extra = tbmp_pkg::EXTRA_QUERY;
      tbmp_pkg::KIND_CATALOG: extra = tbmp_pkg::EXTRA_QUERY;
      default:                extra = '0;
    endcase
  end

  always_comb begin
    if (level_fill < tbmp_pkg::MILLI_PER_TOKEN) begin
      verdict   = tbmp_pkg::VERDICT_RATE;
      level_out = level_fill;
    end else if (!word.parse_ok) begin
      verdict   = tbmp_pkg::VERDICT_PARSE;
      level_out = level_one;
    end else if (level_one < extra) begin
      verdict   = tbmp_pkg::VERDICT_RATE;
      level_out = level_one;
    end else if (word.later_refused) begin
      verdict   = tbmp_pkg::VERDICT_REFUSED;
      level_out = level_one - extra;
    end else begin
      verdict   = tbmp_pkg::VERDICT_ACCEPT;
      level_out = level_one - extra;
    end
  end

  always_comb begin
    state_next = state;
    res        = '{verdict: tbmp_pkg::VERDICT_ACCEPT, close_now: 1'b0, tokens_left: '0};
    if (word.cmd) begin
      state_next = '0;
    end else if (state.is_closing) begin
      res.verdict     = tbmp_pkg::VERDICT_IGNORED;
      res.tokens_left = state.level_milli;
    end else begin
      state_next.level_milli    = level_out;
      state_next.last_time      = last_fill;
      state_next.bucket_started = 1'b1;
      res.verdict               = verdict;
      res.tokens_left           = level_out;
      if (verdict != tbmp_pkg::VERDICT_ACCEPT) begin
        state_next.violation_count = count_inc;
        if (count_inc > cfg.max_violations) begin
          state_next.is_closing = 1'b1;
          res.close_now         = 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/tbmp_checker.sv
// Port-level checks on the policer's result channel, bound to the top level.
// Depends on tbmp_pkg for the verdict codes.
module tbmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic        close_now,
  input logic [19:0] tokens_left
);

  localparam logic [19:0] LEVEL_LIMIT = 20'd1023000;

  // hold a stalled word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(close_now)
      && $stable(tokens_left))
    else $error("result word changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && close_now |-> verdict == tbmp_pkg::VERDICT_RATE
      || verdict == tbmp_pkg::VERDICT_PARSE || verdict == tbmp_pkg::VERDICT_REFUSED)
    else $error("close without a violation");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == tbmp_pkg::VERDICT_RATE |-> tokens_left < 20'd4000)
    else $error("rate limited with enough tokens");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tokens_left <= LEVEL_LIMIT)
    else $error("bucket level beyond largest capacity");

endmodule

bind token_bucket_message_policer_core tbmp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .verdict     (result.verdict),
  .close_now   (result.close_now),
  .tokens_left (result.tokens_left)
);

>>> tb/sv/tb.sv
// Self-checking bench for token_bucket_message_policer_core: directed and random words.
// Predicts each result word itself and compares verdict, close flag and bucket level.
// Depends on tbmp_pkg and the channel interfaces of tbmp_if.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbmp_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 12;
  localparam int WORDS_TARGET  = 1500;

  typedef enum logic [1:0] {
    FEED_WORD,
    FEED_CFG,
    FEED_HOLD
  } feed_kind_t;

  typedef struct {
    feed_kind_t             kind;
    word_t                  word;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } feed_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tbmp_item_if   item_ch ();
  tbmp_result_if result_ch ();

  token_bucket_message_policer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // policer copy: registers and bucket state
  logic [9:0]      cap_tokens   = BURST_TOKENS_RESET;
  logic [16:0]     refill_rate  = REFILL_PER_SECOND_RESET;
  logic [7:0]      strike_limit = MAX_VIOLATIONS_RESET;
  longint unsigned bucket_level = 0;
  longint unsigned bucket_stamp = 0;
  logic            bucket_live  = 1'b0;
  logic [7:0]      strikes      = 8'd0;
  logic            closing      = 1'b0;

  feed_t   pending[$];
  result_t expected_results[$];

  int      words_queued = 0;
  int      sent_cnt = 0;
  int      taken_cnt = 0;
  int      got_cnt = 0;
  int      seen_cnt = 0;
  int      tx_gap = 0;
  int      rx_wait = 0;
  int      settle = 0;
  bit      tx_calm = 1'b0;
  bit      rx_calm = 1'b0;
  int      errors = 0;
  int      reg_writes = 0;
  int      closes_seen = 0;
  int      verdicts_seen[5] = '{default: 0};
  longint unsigned clock_ms;

  function automatic result_t police(word_t w);
    result_t         r;
    longint unsigned cap;
    longint unsigned span;
    longint unsigned add;
    longint unsigned sum;
    longint unsigned extra;
    r.verdict   = VERDICT_ACCEPT;
    r.close_now = 1'b0;
    if (w.cmd) begin
      bucket_level = 0;
      bucket_stamp = 0;
      bucket_live  = 1'b0;
      strikes      = 8'd0;
      closing      = 1'b0;
    end else if (closing) begin
      r.verdict = VERDICT_IGNORED;
    end else begin
      cap = 64'(cap_tokens) * 64'd1000;
      if (!bucket_live) begin
        bucket_level = cap;
        bucket_stamp = w.now_ms;
        bucket_live  = 1'b1;
      end
      if (w.now_ms > bucket_stamp) begin
        span = w.now_ms - bucket_stamp;
        if (span > cap) add = (refill_rate == 0) ? 64'd0 : cap;
        else add = span * 64'(refill_rate);
        sum          = bucket_level + add;
        bucket_level = (sum < cap) ? sum : cap;
        bucket_stamp = w.now_ms;
      end
      case (kind_t'(w.command_kind))
        KIND_OTHER: extra = 0;
        KIND_STATE: extra = 2000;
        default:    extra = 4000;
      endcase
      if (bucket_level < 1000) begin
        r.verdict = VERDICT_RATE;
      end else begin
        bucket_level -= 1000;
        if (!w.parse_ok) begin
          r.verdict = VERDICT_PARSE;
        end else if (bucket_level < extra) begin
          r.verdict = VERDICT_RATE;
        end else begin
          bucket_level -= extra;
          if (w.later_refused) r.verdict = VERDICT_REFUSED;
        end
      end
      if (r.verdict != VERDICT_ACCEPT) begin
        if (strikes != 8'd255) strikes++;
        if (strikes > strike_limit) begin
          closing     = 1'b1;
          r.close_now = 1'b1;
        end
      end
    end
    r.tokens_left = bucket_level[19:0];
    return r;
  endfunction

  task automatic push_word(logic cmd, longint unsigned now, logic parse_ok, kind_t kind,
                           logic refused);
    feed_t f;
    f.kind               = FEED_WORD;
    f.word.cmd           = cmd;
    f.word.now_ms        = now;
    f.word.parse_ok      = parse_ok;
    f.word.command_kind  = kind;
    f.word.later_refused = refused;
    f.index              = '0;
    f.data               = '0;
    pending.insert(pending.size(), f);
    words_queued++;
  endtask

  task automatic push_cfg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    feed_t f;
    f.kind  = FEED_CFG;
    f.word  = '0;
    f.index = index;
    f.data  = data;
    pending.insert(pending.size(), f);
  endtask

  task automatic push_hold();
    feed_t f;
    f.kind  = FEED_HOLD;
    f.word  = '0;
    f.index = '0;
    f.data  = '0;
    pending.insert(pending.size(), f);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always #1 clk = ~clk;

  // sender: one word at a time, random gap before each; register writes wait until the core is idle
  always @(negedge clk) begin : drive_words
    logic  live;
    logic  we;
    feed_t head;
    we   = 1'b0;
    live = item_ch.valid && (taken_cnt != sent_cnt);
    if (!rst) begin
      settle = (expected_results.size() == 0 && taken_cnt == sent_cnt) ? settle + 1 : 0;
      if (!live && tx_gap > 0) begin
        tx_gap--;
      end else if (!live && pending.size() > 0) begin
        head = pending[0];
        if (head.kind == FEED_WORD) begin
          item_ch.cmd           <= head.word.cmd;
          item_ch.now_ms        <= head.word.now_ms;
          item_ch.parse_ok      <= head.word.parse_ok;
          item_ch.command_kind  <= head.word.command_kind;
          item_ch.later_refused <= head.word.later_refused;
          live = 1'b1;
          sent_cnt++;
          void'(pending.pop_front());
          if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
          tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
        end else if (settle >= SETTLE_CYCLES) begin
          if (head.kind == FEED_CFG) begin
            we = 1'b1;
            cfg_index <= head.index;
            cfg_data  <= head.data;
          end
          void'(pending.pop_front());
          settle = 0;
        end
      end
    end
    item_ch.valid <= live;
    cfg_write     <= we;
  end

  // receiver: random stall after each result word
  always @(negedge clk) begin
    if (got_cnt != seen_cnt) begin
      seen_cnt = got_cnt;
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
    end
    if (rx_wait > 0) begin
      rx_wait--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    word_t   w;
    if (!rst) begin
      if (cfg_write) begin
        reg_writes++;
        case (cfg_index)
          CFG_BURST_TOKENS:      cap_tokens   = cfg_data[9:0];
          CFG_REFILL_PER_SECOND: refill_rate  = cfg_data[16:0];
          CFG_MAX_VIOLATIONS:    strike_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (result_ch.valid && result_ch.ready) begin
        got_cnt <= got_cnt + 1;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual verdict %0d close %0b level %0d",
                   $time, result_ch.verdict, result_ch.close_now, result_ch.tokens_left);
        end else begin
          want = expected_results.pop_front();
          check_field("verdict", want.verdict, result_ch.verdict);
          check_field("close_now", want.close_now, result_ch.close_now);
          check_field("tokens_left", want.tokens_left, result_ch.tokens_left);
          verdicts_seen[want.verdict]++;
          if (want.close_now) closes_seen++;
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        taken_cnt <= taken_cnt + 1;
        w.cmd           = item_ch.cmd;
        w.now_ms        = item_ch.now_ms;
        w.parse_ok      = item_ch.parse_ok;
        w.command_kind  = item_ch.command_kind;
        w.later_refused = item_ch.later_refused;
        expected_results.insert(expected_results.size(), police(w));
      end
    end
  end

  initial begin
    #400000;
    $display("timeout at %0t with %0d results outstanding", $time, expected_results.size());
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int               pick;
    logic [9:0]       burst;
    logic [16:0]      rate;
    logic [7:0]       limit;
    clk                   = 1'b0;
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    item_ch.valid         = 1'b0;
    item_ch.cmd           = 1'b0;
    item_ch.now_ms        = '0;
    item_ch.parse_ok      = 1'b0;
    item_ch.command_kind  = '0;
    item_ch.later_refused = 1'b0;
    result_ch.ready       = 1'b0;

    // full bucket, every kind, parse failure, refusal, failed second charge
    push_word(1'b0, 64'd100, 1'b1, KIND_OTHER, 1'b0);
    push_word(1'b0, 64'd100, 1'b1, KIND_STATE, 1'b0);
    push_word(1'b0, 64'd100, 1'b1, KIND_FIGHT, 1'b0);
    push_word(1'b0, 64'd100, 1'b1, KIND_CATALOG, 1'b0);
    push_word(1'b0, 64'd100, 1'b0, KIND_OTHER, 1'b0);
    push_word(1'b0, 64'd100, 1'b1, KIND_OTHER, 1'b1);
    push_word(1'b0, 64'd100, 1'b1, KIND_CATALOG, 1'b0);
    // time backwards, then a huge jump, then back to zero
    push_word(1'b0, 64'd50, 1'b1, KIND_OTHER, 1'b0);
    push_word(1'b0, '1, 1'b1, KIND_STATE, 1'b0);
    push_word(1'b0, 64'd0, 1'b0, KIND_FIGHT, 1'b1);
    // run the violation count past the limit, then one ignored, then reconnect
    repeat (7) push_word(1'b0, '1, 1'b0, KIND_OTHER, 1'b0);
    push_word(1'b0, '1, 1'b1, KIND_OTHER, 1'b0);
    push_word(1'b1, '1, 1'b1, KIND_CATALOG, 1'b1);
    // empty bucket, no refill, never close
    push_cfg(CFG_MAX_VIOLATIONS, 17'd255);
    push_cfg(CFG_BURST_TOKENS, 17'd0);
    push_cfg(CFG_REFILL_PER_SECOND, 17'd0);
    push_word(1'b0, 64'd5, 1'b1, KIND_OTHER, 1'b0);
    push_word(1'b0, 64'd900, 1'b1, KIND_OTHER, 1'b0);
    // lower the cap under the level: clamp only on a refill
    push_cfg(CFG_BURST_TOKENS, 17'd1000);
    push_cfg(CFG_REFILL_PER_SECOND, 17'd100000);
    push_word(1'b1, 64'd0, 1'b0, KIND_OTHER, 1'b0);
    push_word(1'b0, 64'd10, 1'b1, KIND_OTHER, 1'b0);
    push_cfg(CFG_BURST_TOKENS, 17'd1);
    push_word(1'b0, 64'd10, 1'b1, KIND_OTHER, 1'b0);
    push_word(1'b0, 64'd11, 1'b1, KIND_OTHER, 1'b0);
    push_word(1'b0, 64'd11, 1'b1, KIND_OTHER, 1'b0);

    clock_ms = 0;
    while (words_queued < WORDS_TARGET) begin
      case ($urandom_range(0, 7))
        0:       burst = 10'd0;
        1:       burst = 10'd1;
        2:       burst = 10'd1000;
        default: burst = 10'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 7))
        0:       rate = 17'd0;
        1:       rate = 17'd100000;
        2:       rate = 17'($urandom_range(0, 100000));
        default: rate = 17'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 7))
        0:       limit = 8'd0;
        1:       limit = 8'd255;
        2:       limit = 8'd254;
        default: limit = 8'($urandom_range(1, 20));
      endcase
      push_cfg(CFG_BURST_TOKENS, 17'(burst));
      push_cfg(CFG_REFILL_PER_SECOND, rate);
      push_cfg(CFG_MAX_VIOLATIONS, 17'(limit));
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 4) != 0)
          push_word(1'b1, {$urandom, $urandom}, 1'($urandom), kind_t'($urandom_range(0, 3)),
                    1'($urandom));
        repeat ($urandom_range(5, 40)) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            push_word(1'($urandom), {$urandom, $urandom}, 1'($urandom),
                      kind_t'($urandom_range(0, 3)), 1'($urandom));
          end else begin
            case ($urandom_range(0, 15))
              0:       clock_ms = {$urandom, $urandom};
              1:       clock_ms -= $urandom_range(1, 50);
              2, 3:    ;
              default: clock_ms += $urandom_range(1, 30);
            endcase
            push_word(1'b0, clock_ms, 1'($urandom_range(0, 9) != 0),
                      kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 6) == 0));
          end
        end
      end
      push_hold();
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    do @(posedge clk);
    while (pending.size() != 0 || taken_cnt != sent_cnt || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d words, %0d register writes, %0d closes", sent_cnt, reg_writes,
             closes_seen);
    $display("summary: verdicts accept %0d ignored %0d rate %0d parse %0d refused %0d",
             verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], verdicts_seen[3],
             verdicts_seen[4]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
